@@ rtl/core/dtq_pkg.sv @@
// dtq_pkg: shared widths, codes and types of the deadline timer queue
// used by dtq_cell, dtq_park and deadline_timer_queue; no dependencies
package dtq_pkg;

  localparam int DL_W            = 48;
  localparam int ID_W            = 32;
  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_PARK_DEPTH  = 8;
  localparam int MAX_RESULTS     = 32;
  localparam int RCW             = $clog2(MAX_RESULTS + 1);

  // stream payload widths
  localparam int S_TDATA_W = 128;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 136;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_DEFER = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    cell_op_t        op;
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] id;
  } cell_cmd_t;

endpackage

@@ rtl/core/dtq_cell.sv @@
// dtq_cell: one slot of the sorted timer chain
// depends on dtq_pkg; neighbors hand entries over on insert and pop
module dtq_cell (
  input  logic            clk,
  input  dtq_pkg::cell_cmd_t cmd,
  input  logic            occ,
  input  logic            prev_gt,
  input  dtq_pkg::entry_t prev_ent,
  input  dtq_pkg::entry_t next_ent,
  output logic            gt,
  output dtq_pkg::entry_t ent
);
  import dtq_pkg::*;

  logic later;

  // strictly later deadline moves back, equal deadlines stay ahead
  assign later = ent.dl > cmd.dl;
  assign gt    = occ && later;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INSERT: begin
        if (prev_gt) begin
          ent <= prev_ent;
        end else if (!occ || later) begin
          ent <= '{dl: cmd.dl, id: cmd.id};
        end
      end
      OP_POP: begin
        ent <= next_ent;
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/dtq_park.sv @@
// dtq_park: side buffer of deferred timers, drained in parking order
// depends on dtq_pkg
module dtq_park #(
  parameter int PARK_DEPTH = dtq_pkg::DEF_PARK_DEPTH,
  parameter int PCW        = $clog2(PARK_DEPTH + 1),
  parameter int PIW        = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  dtq_pkg::entry_t        wr_ent,
  input  logic                   clr,
  input  logic [PIW-1:0]         rd_idx,
  output dtq_pkg::entry_t        rd_ent,
  output logic [PCW-1:0]         count,
  output logic                   full
);
  import dtq_pkg::*;

  entry_t slots [PARK_DEPTH];

  assign full   = count == PCW'(PARK_DEPTH);
  assign rd_ent = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[count[PIW-1:0]] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clr) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + PCW'(1);
    end
  end

endmodule

@@ rtl/core/deadline_timer_queue.sv @@
// deadline_timer_queue: earliest-deadline timer queue on a chain of cells
// push, deferred push and clear: result loaded from S_FINAL once the result register is free
// tick: pops k expired entries (one pop per cycle, at most 32), then inserts p parked
//   entries (one insert per cycle); a waiting result that is not taken stalls the pops
// one item in flight: a new transfer is taken only back in S_IDLE, after its result; reset empties
// queue and side buffer, idle_deadline all ones, entry storage itself is not cleared
module deadline_timer_queue #(
  parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH,
  parameter int PARK_DEPTH  = dtq_pkg::DEF_PARK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: idle_deadline
  input  logic                            cfg_wr_en,
  input  logic [dtq_pkg::DL_W-1:0]        cfg_wr_data,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // deadline [47:0], conn_id [79:48], now [127:80]
  input  logic [dtq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // func [1:0]
  input  logic [dtq_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // fired_id [31:0], fire_time [79:32], next_deadline [127:80], dropped [128], zeros above
  output logic [dtq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // fired [0]
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import dtq_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int PCW = $clog2(PARK_DEPTH + 1);
  localparam int PIW = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DRAIN,
    S_FINAL
  } state_t;

  // input fields
  logic [DL_W-1:0] in_dl;
  logic [ID_W-1:0] in_id;
  logic [DL_W-1:0] in_now;
  func_t           in_func;

  assign in_dl   = s_axis_tdata[47:0];
  assign in_id   = s_axis_tdata[79:48];
  assign in_now  = s_axis_tdata[127:80];
  assign in_func = func_t'(s_axis_tuser);

  // control registers
  state_t          state;
  logic [QCW-1:0]  count;
  logic [RCW-1:0]  n_popped;
  logic [PCW-1:0]  drain_idx;
  logic            pend_valid;
  logic [ID_W-1:0] pend_id;
  logic [DL_W-1:0] tick_now;
  logic            drop_flag;
  logic [DL_W-1:0] idle_deadline;

  // chain wiring
  cell_cmd_t cmd;
  logic      gt_w   [QUEUE_DEPTH];
  entry_t    ent_w  [QUEUE_DEPTH];

  // side buffer wiring
  logic           park_wr;
  logic           park_clr;
  entry_t         park_wr_ent;
  entry_t         park_rd;
  logic [PCW-1:0] park_count;
  logic           park_full;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic            q_full;
  logic            head_exp;
  logic [DL_W-1:0] next_dl;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign q_full        = count == QCW'(QUEUE_DEPTH);
  assign next_dl       = (count != '0) ? ent_w[0].dl : idle_deadline;
  // head has expired and the per-tick report budget is not used up
  assign head_exp      = (count != '0) && (ent_w[0].dl <= tick_now) &&
                         (n_popped < RCW'(MAX_RESULTS));
  // result register takes a new transfer this cycle
  assign out_load      = out_free && ((state == S_FINAL) ||
                                      (state == S_TICK && head_exp && pend_valid));
  assign park_wr_ent   = '{dl: in_dl, id: in_id};

  // the cell chain: each cell sees its own slot and both neighbors
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_gt;
    entry_t prev_ent;
    entry_t next_ent;
    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_ent = ent_w[i];
    end else begin : g_mid
      assign prev_gt  = gt_w[i-1];
      assign prev_ent = ent_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_ent = ent_w[i];
    end else begin : g_body
      assign next_ent = ent_w[i+1];
    end
    dtq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occ      (count > QCW'(i)),
      .prev_gt  (prev_gt),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .gt       (gt_w[i]),
      .ent      (ent_w[i])
    );
  end

  dtq_park #(
    .PARK_DEPTH (PARK_DEPTH),
    .PCW        (PCW),
    .PIW        (PIW)
  ) u_park (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (park_wr),
    .wr_ent (park_wr_ent),
    .clr    (park_clr),
    .rd_idx (drain_idx[PIW-1:0]),
    .rd_ent (park_rd),
    .count  (park_count),
    .full   (park_full)
  );

  // chain command and side buffer strobes
  always_comb begin
    cmd      = '{op: OP_HOLD, dl: in_dl, id: in_id};
    park_wr  = 1'b0;
    park_clr = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && in_func == FUNC_PUSH && !q_full) begin
          cmd.op = OP_INSERT;
        end
        park_wr = accept && in_func == FUNC_DEFER && !park_full;
      end
      S_TICK: begin
        // pop only when the waiting report can leave at the same time
        if (head_exp && (!pend_valid || out_free)) begin
          cmd.op = OP_POP;
        end
      end
      S_DRAIN: begin
        cmd.dl = park_rd.dl;
        cmd.id = park_rd.id;
        if (drain_idx != park_count && !q_full) begin
          cmd.op = OP_INSERT;
        end
        park_clr = drain_idx == park_count;
      end
      S_FINAL: begin
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_deadline <= {DL_W{1'b1}};
    end else if (cfg_wr_en) begin
      idle_deadline <= cfg_wr_data;
    end
  end

  // sequencer, queue count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      n_popped      <= '0;
      drain_idx     <= '0;
      pend_valid    <= 1'b0;
      drop_flag     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_valid <= 1'b0;
            unique case (in_func)
              FUNC_PUSH: begin
                drop_flag <= q_full;
                if (!q_full) begin
                  count <= count + QCW'(1);
                end
                state <= S_FINAL;
              end
              FUNC_DEFER: begin
                drop_flag <= park_full;
                state     <= S_FINAL;
              end
              FUNC_TICK: begin
                drop_flag <= 1'b0;
                tick_now  <= in_now;
                n_popped  <= '0;
                state     <= S_TICK;
              end
              FUNC_CLEAR: begin
                drop_flag <= 1'b0;
                count     <= '0;
                state     <= S_FINAL;
              end
              default: begin
              end
            endcase
          end
        end
        S_TICK: begin
          if (head_exp) begin
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                // earlier report: next deadline is the head left after its removal
                m_axis_tuser  <= 1'b1;
                m_axis_tlast  <= 1'b0;
                m_axis_tdata  <= {7'd0, 1'b0, next_dl, tick_now, pend_id};
              end
              pend_valid <= 1'b1;
              pend_id    <= ent_w[0].id;
              count      <= count - QCW'(1);
              n_popped   <= n_popped + RCW'(1);
            end
          end else begin
            drain_idx <= '0;
            state     <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_idx == park_count) begin
            state <= S_FINAL;
          end else begin
            if (q_full) begin
              drop_flag <= 1'b1;
            end else begin
              count <= count + QCW'(1);
            end
            drain_idx <= drain_idx + PCW'(1);
          end
        end
        S_FINAL: begin
          if (out_free) begin
            m_axis_tuser  <= pend_valid;
            m_axis_tlast  <= 1'b1;
            m_axis_tdata  <= {7'd0, drop_flag, next_dl,
                              pend_valid ? tick_now : {DL_W{1'b0}},
                              pend_valid ? pend_id : {ID_W{1'b0}}};
            pend_valid    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // the two front cells stay in deadline order
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= QCW'(2)) |-> (ent_w[0].dl <= ent_w[1].dl))
    else $error("chain head out of order");

  // a tick never reports more than the result budget
  a_pop_budget: assert property (@(posedge clk) disable iff (rst)
    n_popped <= RCW'(MAX_RESULTS))
    else $error("tick reported too many timers");

  // no report is left waiting once the block is ready again
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending report in idle");

  // a pop in the chain always goes with a one lower count
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_POP) |=> (count == $past(count) - QCW'(1)))
    else $error("pop without count update");

endmodule

@@ test/tb.sv @@
// tb: self-checking testbench for deadline_timer_queue (directed table, then random traffic)
// depends on dtq_pkg and the deadline_timer_queue rtl; predicts every result internally
module tb;
  import dtq_pkg::*;

  localparam logic [DL_W-1:0] DL_MAX      = '1;
  localparam int              QDEPTH      = DEF_QUEUE_DEPTH;
  localparam int              PDEPTH      = DEF_PARK_DEPTH;
  // settle time: covers the worst tick with 32 pops and 8 parked inserts, plus margin
  localparam int              SETTLE_CYC  = 60;

  // one expected result transfer
  typedef struct packed {
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic [DL_W-1:0] fire_time;
    logic [DL_W-1:0] next_dl;
    logic            dropped;
    logic            last;
  } timer_result_t;

  // one row of the directed table; lit marks a row whose single result is typed in
  typedef struct packed {
    func_t           f;
    logic [DL_W-1:0] dl;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] nw;
    logic            lit;
    logic [DL_W-1:0] lit_next;
    logic            lit_drop;
  } timer_step_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [DL_W-1:0]      cfg_wr_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  deadline_timer_queue dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // timer queue model: sorted queue, side buffer, idle deadline register
  // ---------------------------------------------------------------------------
  logic [DL_W-1:0] tq_dl [QDEPTH];
  logic [ID_W-1:0] tq_id [QDEPTH];
  int              tq_n;
  logic [DL_W-1:0] pk_dl [PDEPTH];
  logic [ID_W-1:0] pk_id [PDEPTH];
  int              pk_n;
  logic [DL_W-1:0] idle_dl;

  timer_result_t   results_due[$];   // expected result transfers, oldest first
  int              mismatch_count;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              rx_hold_len;      // request for a long receiver hold-off
  logic [DL_W-1:0] sim_now;          // running notion of time for random ticks

  function automatic logic [DL_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[DL_W-1:0];
  endfunction

  function automatic logic [DL_W-1:0] tq_next();
    return (tq_n > 0) ? tq_dl[0] : idle_dl;
  endfunction

  // insert behind every entry that is not later, so ties keep arrival order
  function automatic bit tq_insert(logic [DL_W-1:0] dl, logic [ID_W-1:0] id);
    int pos;
    if (tq_n >= QDEPTH) return 1'b0;
    pos = tq_n;
    while (pos > 0 && tq_dl[pos-1] > dl) pos--;
    for (int k = tq_n; k > pos; k--) begin
      tq_dl[k] = tq_dl[k-1];
      tq_id[k] = tq_id[k-1];
    end
    tq_dl[pos] = dl;
    tq_id[pos] = id;
    tq_n++;
    return 1'b1;
  endfunction

  function automatic void tq_pop();
    for (int k = 1; k < tq_n; k++) begin
      tq_dl[k-1] = tq_dl[k];
      tq_id[k-1] = tq_id[k];
    end
    if (tq_n > 0) tq_n--;
  endfunction

  // update the model for one accepted transfer and queue its results
  function automatic void predict_timers(func_t f, logic [DL_W-1:0] dl,
                                         logic [ID_W-1:0] id, logic [DL_W-1:0] nw);
    logic [ID_W-1:0] exp_ids[$];
    logic [DL_W-1:0] exp_nds[$];
    logic            lost;
    timer_result_t   r;
    lost = 1'b0;
    r    = '0;
    case (f)
      FUNC_PUSH: begin
        lost = !tq_insert(dl, id);
      end
      FUNC_DEFER: begin
        if (pk_n < PDEPTH) begin
          pk_dl[pk_n] = dl;
          pk_id[pk_n] = id;
          pk_n++;
        end else begin
          lost = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        tq_n = 0;
      end
      default: begin
        // tick: pop expired entries, then move parked entries over in park order
        while (exp_ids.size() < MAX_RESULTS && tq_n > 0 && tq_dl[0] <= nw) begin
          exp_ids = {exp_ids, tq_id[0]};
          tq_pop();
          exp_nds = {exp_nds, tq_next()};
        end
        for (int k = 0; k < pk_n; k++)
          if (!tq_insert(pk_dl[k], pk_id[k])) lost = 1'b1;
        pk_n = 0;
      end
    endcase
    if (exp_ids.size() == 0) begin
      r.next_dl = tq_next();
      r.dropped = lost;
      r.last    = 1'b1;
      results_due = {results_due, r};
    end else begin
      foreach (exp_ids[k]) begin
        r.fired     = 1'b1;
        r.fired_id  = exp_ids[k];
        r.fire_time = nw;
        r.last      = (k == exp_ids.size() - 1);
        // the final result sees the queue after parked entries came in
        r.next_dl   = r.last ? tq_next() : exp_nds[k];
        r.dropped   = r.last && lost;
        results_due = {results_due, r};
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, with an occasional long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        hold        = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [DL_W-1:0] exp_v,
                                      logic [DL_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // result monitor: every transfer is matched against the oldest expectation
  timer_result_t seen_exp;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: tdata %0h", m_axis_tdata);
        mismatch_count++;
      end else begin
        seen_exp = results_due.pop_front();
        check_field("fired",         DL_W'(seen_exp.fired),    DL_W'(m_axis_tuser));
        check_field("fired_id",      DL_W'(seen_exp.fired_id), DL_W'(m_axis_tdata[31:0]));
        check_field("fire_time",     seen_exp.fire_time,       m_axis_tdata[79:32]);
        check_field("next_deadline", seen_exp.next_dl,         m_axis_tdata[127:80]);
        check_field("dropped",       DL_W'(seen_exp.dropped),  DL_W'(m_axis_tdata[128]));
        check_field("last",          DL_W'(seen_exp.last),     DL_W'(m_axis_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------
  // offer one item from the falling edge, wait for its transfer, then predict
  task automatic drive_item(func_t f, logic [DL_W-1:0] dl, logic [ID_W-1:0] id,
                            logic [DL_W-1:0] nw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nw, id, dl};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    predict_timers(f, dl, id, nw);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_idle_deadline(logic [DL_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    idle_dl = v;
  endtask

  // overfill queue and side buffer, tick with nothing due so parked entries
  // hit a full queue, then tick far enough ahead that every pushed deadline is due
  task automatic fill_and_flush();
    for (int i = 0; i < QDEPTH + 2; i++)
      drive_item(FUNC_PUSH, sim_now + $urandom_range(60, 1), $urandom, rand48());
    for (int i = 0; i < PDEPTH + 1; i++)
      drive_item(FUNC_DEFER, sim_now + $urandom_range(60, 1), $urandom, rand48());
    drive_item(FUNC_TICK, rand48(), $urandom, sim_now);
    sim_now = sim_now + 100;
    drive_item(FUNC_TICK, rand48(), $urandom, sim_now);
  endtask

  // mostly near-future deadlines around a moving clock, some wild values
  task automatic random_item();
    func_t           f;
    logic [DL_W-1:0] dl;
    logic [DL_W-1:0] nw;
    int              r;
    r  = $urandom_range(99);
    if (r < 45) begin
      f = FUNC_PUSH;
    end else if (r < 62) begin
      f = FUNC_DEFER;
    end else if (r < 95) begin
      f = FUNC_TICK;
    end else begin
      f = FUNC_CLEAR;
    end
    dl = rand48();
    nw = rand48();
    if (f == FUNC_PUSH || f == FUNC_DEFER) begin
      case ($urandom_range(9))
        0:       dl = rand48();
        1:       dl = sim_now;
        default: dl = sim_now + $urandom_range(200);
      endcase
    end else if (f == FUNC_TICK && $urandom_range(9) != 0) begin
      sim_now = sim_now + $urandom_range(80);
      nw      = sim_now;
    end
    drive_item(f, dl, $urandom, nw);
  endtask

  // directed table: extremes, every function, ties, clear keeping parked entries
  timer_step_t directed_steps [16] = '{
    '{FUNC_TICK,  48'd0,   32'd0,          48'd0,   1'b1, DL_MAX, 1'b0}, // empty after reset
    '{FUNC_PUSH,  48'd0,   32'd0,          DL_MAX,  1'b1, 48'd0,  1'b0},
    '{FUNC_PUSH,  DL_MAX,  32'hffff_ffff,  48'd0,   1'b1, 48'd0,  1'b0},
    '{FUNC_PUSH,  48'd100, 32'd1,          48'd0,   1'b0, 48'd0,  1'b0},
    '{FUNC_PUSH,  48'd100, 32'd2,          48'd0,   1'b0, 48'd0,  1'b0}, // tie keeps order
    '{FUNC_PUSH,  48'd99,  32'd3,          48'd0,   1'b0, 48'd0,  1'b0},
    '{FUNC_DEFER, 48'd50,  32'd4,          48'd0,   1'b1, 48'd0,  1'b0},
    '{FUNC_DEFER, DL_MAX,  32'd5,          48'd0,   1'b0, 48'd0,  1'b0},
    '{FUNC_TICK,  48'd0,   32'd0,          48'd100, 1'b0, 48'd0,  1'b0}, // burst, then unpark
    '{FUNC_TICK,  48'd0,   32'd0,          48'd49,  1'b0, 48'd0,  1'b0}, // nothing due
    '{FUNC_TICK,  48'd0,   32'd0,          DL_MAX,  1'b0, 48'd0,  1'b0}, // everything due
    '{FUNC_PUSH,  48'd7,   32'd6,          48'd0,   1'b0, 48'd0,  1'b0},
    '{FUNC_DEFER, 48'd8,   32'd7,          48'd0,   1'b0, 48'd0,  1'b0},
    '{FUNC_CLEAR, 48'd0,   32'd0,          48'd0,   1'b1, DL_MAX, 1'b0}, // parked kept
    '{FUNC_TICK,  48'd0,   32'd0,          48'd0,   1'b1, 48'd8,  1'b0}, // parked moves in
    '{FUNC_CLEAR, DL_MAX,  32'hffff_ffff,  DL_MAX,  1'b1, DL_MAX, 1'b0}
  };

  initial begin
    timer_result_t lit_r;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    rx_hold_len    = 0;
    mismatch_count = 0;
    tq_n           = 0;
    pk_n           = 0;
    idle_dl        = DL_MAX;
    sim_now        = 48'd1000;
    send_idle_pct  = 12;
    recv_idle_pct  = 83;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      drive_item(directed_steps[i].f, directed_steps[i].dl, directed_steps[i].id,
                 directed_steps[i].nw);
      if (directed_steps[i].lit) begin
        // swap the predicted single result for the typed-in one
        lit_r         = '0;
        lit_r.next_dl = directed_steps[i].lit_next;
        lit_r.dropped = directed_steps[i].lit_drop;
        lit_r.last    = 1'b1;
        void'(results_due.pop_back());
        results_due = {results_due, lit_r};
      end
    end

    // three idling profiles, each under its own idle deadline
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       write_idle_deadline(48'd0);
        1:       write_idle_deadline(rand48());
        default: write_idle_deadline(DL_MAX);
      endcase
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 12 : 0;
      fill_and_flush();
      for (int i = 0; i < 110; i++) begin
        // receiver goes quiet while items keep coming, so the input stalls
        if (ph == 2 && i == 10) rx_hold_len = 300;
        // sender holds back until the result stream has fully drained
        if (ph == 1 && i == 50) wait_drained();
        random_item();
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    for (int c = 0; c < 200000 && results_due.size() > 0; c++) @(posedge clk);
    if (results_due.size() > 0) begin
      $error("%0d expected results never arrived", results_due.size());
      mismatch_count++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ deadline_timer_queue.f @@
rtl/core/dtq_pkg.sv
rtl/core/dtq_cell.sv
rtl/core/dtq_park.sv
rtl/core/deadline_timer_queue.sv
test/tb.sv
